@@ hw/rtl/lc3_pkg.sv @@
// lc3_pkg: shared types, codes and constants of the lc-3 instruction core
// no dependencies; used by lc3_ctrl, lc3_dp and the top level of the core
package lc3_pkg;

    // memory address width and reset values
    localparam int ADDR_BITS = 16;
    localparam int MEM_WORDS = 2 ** ADDR_BITS;
    localparam logic [15:0] START_RESET = 16'h3000;

    // item function codes
    localparam logic [1:0] FN_WRITE   = 2'd0;
    localparam logic [1:0] FN_READ    = 2'd1;
    localparam logic [1:0] FN_RESTART = 2'd2;
    localparam logic [1:0] FN_STEP    = 2'd3;

    // opcodes
    localparam logic [3:0] OP_BR  = 4'd0;
    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_LD  = 4'd2;
    localparam logic [3:0] OP_ST  = 4'd3;
    localparam logic [3:0] OP_JSR = 4'd4;
    localparam logic [3:0] OP_AND = 4'd5;
    localparam logic [3:0] OP_LDR = 4'd6;
    localparam logic [3:0] OP_STR = 4'd7;
    localparam logic [3:0] OP_NOT = 4'd9;
    localparam logic [3:0] OP_LDI = 4'd10;
    localparam logic [3:0] OP_STI = 4'd11;
    localparam logic [3:0] OP_JMP = 4'd12;
    localparam logic [3:0] OP_LEA = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    // trap vectors
    localparam logic [7:0] TV_GETC = 8'h20;
    localparam logic [7:0] TV_OUT  = 8'h21;
    localparam logic [7:0] TV_IN   = 8'h23;
    localparam logic [7:0] TV_HALT = 8'h25;

    // condition code bits
    localparam logic [2:0] CC_N = 3'd4;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_P = 3'd1;

    // configuration register word index
    localparam logic REG_START_PC = 1'b0;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] addr;
        logic [15:0] data;
        logic [7:0]  char_in;
    } item_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [15:0] pc_now;
        logic [2:0]  flags;
        logic        halted;
        logic        char_valid;
        logic [7:0]  char_out;
        logic        took_char;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic item_load;
        logic clear;
        logic mem_write;
        logic mem_read;
        logic restart;
        logic fetch;
        logic decode;
        logic operand;
        logic exec;
        logic indirect;
        logic load_data;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [3:0] opcode;
        logic       halted;
        logic       clear_last;
    } sts_t;

endpackage

@@ hw/rtl/lc3_ram.sv @@
// lc3_ram: generic single write port, single read port ram with registered read
// no dependencies
module lc3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/lc3_ctrl.sv @@
// lc3_ctrl: sequencing state machine of the lc-3 core
// depends on lc3_pkg; drives the datapath through cmd_t, reads sts_t
module lc3_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic [1:0]      item_func,
    output logic            item_stall,
    output logic            result_valid,
    input  logic            result_stall,
    input  lc3_pkg::sts_t   sts,
    output lc3_pkg::cmd_t   cmd
);
    import lc3_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_WRITE = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_RST   = 4'd4;
    localparam logic [3:0] S_FETCH = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_OPND  = 4'd7;
    localparam logic [3:0] S_EXEC  = 4'd8;
    localparam logic [3:0] S_IND   = 4'd9;
    localparam logic [3:0] S_LOAD  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign accept       = (state_reg == S_IDLE) && item_valid;
    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item_func)
                        FN_WRITE:   state_next = S_WRITE;
                        FN_READ:    state_next = S_READ;
                        FN_RESTART: state_next = S_RST;
                        default:    state_next = sts.halted ? S_FIN : S_FETCH;
                    endcase
                end
            end
            S_WRITE: state_next = S_FIN;
            S_READ:  state_next = S_FIN;
            S_RST:   state_next = S_FIN;
            S_FETCH: state_next = S_DEC;
            S_DEC:   state_next = S_OPND;
            S_OPND:  state_next = S_EXEC;
            S_EXEC:
            begin
                unique case (sts.opcode)
                    OP_LD, OP_LDR:  state_next = S_LOAD;
                    OP_LDI, OP_STI: state_next = S_IND;
                    default:        state_next = S_FIN;
                endcase
            end
            S_IND:   state_next = (sts.opcode == OP_LDI) ? S_LOAD : S_FIN;
            S_LOAD:  state_next = S_FIN;
            S_FIN:   state_next = S_OUT;
            S_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands
    always_comb
    begin
        cmd           = '0;
        cmd.item_load = accept;
        cmd.clear     = (state_reg == S_CLEAR);
        cmd.mem_write = (state_reg == S_WRITE);
        cmd.mem_read  = (state_reg == S_READ);
        cmd.restart   = (state_reg == S_RST);
        cmd.fetch     = (state_reg == S_FETCH);
        cmd.decode    = (state_reg == S_DEC);
        cmd.operand   = (state_reg == S_OPND);
        cmd.exec      = (state_reg == S_EXEC);
        cmd.indirect  = (state_reg == S_IND);
        cmd.load_data = (state_reg == S_LOAD);
        cmd.finish    = (state_reg == S_FIN);
    end
endmodule

@@ hw/rtl/lc3_dp.sv @@
// lc3_dp: datapath of the lc-3 core: main memory, register file, pc, flags
// depends on lc3_pkg and lc3_ram; driven by lc3_ctrl through cmd_t
module lc3_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  lc3_pkg::cmd_t     cmd,
    output lc3_pkg::sts_t     sts,
    input  lc3_pkg::item_t    item,
    input  logic [15:0]       start_pc,
    output lc3_pkg::result_t  result
);
    import lc3_pkg::*;

    // main memory ports
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [15:0]          mem_wdata;
    logic [ADDR_BITS-1:0] mem_raddr;
    logic [15:0]          mem_rdata;

    // register file ports
    logic        rf_we;
    logic [2:0]  rf_waddr;
    logic [15:0] rf_wdata;
    logic [2:0]  rf_raddr;
    logic [15:0] rf_rdata;
    logic [7:0]  rf_vld_reg;
    logic        rf_rvld_reg;
    logic [15:0] rf_val;

    // state
    item_t                item_reg;
    logic [15:0]          ins_reg;
    logic [15:0]          a_reg;
    logic [15:0]          b_reg;
    logic [15:0]          pc_reg;
    logic [15:0]          pc_next;
    logic [2:0]           cc_reg;
    logic                 halt_reg;
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic                 cvalid_reg;
    logic [7:0]           cout_reg;
    logic                 took_reg;
    result_t              result_reg;

    // decoded fields
    logic [3:0]  op;
    logic [2:0]  dr;
    logic [15:0] off6;
    logic [15:0] off9;
    logic [15:0] off11;
    logic [15:0] imm5;
    logic [15:0] opnd2;
    logic [15:0] pcoff;
    logic [15:0] baseoff;
    logic [15:0] alu;
    logic [7:0]  vec;
    logic        set_cc;
    logic [15:0] cc_val;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] c;
        if (v == 16'd0)
        begin
            c = CC_Z;
        end
        else if (v[15])
        begin
            c = CC_N;
        end
        else
        begin
            c = CC_P;
        end
        return c;
    endfunction

    assign op      = ins_reg[15:12];
    assign dr      = ins_reg[11:9];
    assign vec     = ins_reg[7:0];
    assign off6    = {{10{ins_reg[5]}}, ins_reg[5:0]};
    assign off9    = {{7{ins_reg[8]}}, ins_reg[8:0]};
    assign off11   = {{5{ins_reg[10]}}, ins_reg[10:0]};
    assign imm5    = {{11{ins_reg[4]}}, ins_reg[4:0]};
    assign rf_val  = rf_rvld_reg ? rf_rdata : 16'd0;
    assign opnd2   = ins_reg[5] ? imm5 : rf_val;
    assign pcoff   = pc_reg + off9;
    assign baseoff = a_reg + off6;

    // alu
    always_comb
    begin
        case (op)
            OP_ADD:  alu = a_reg + opnd2;
            OP_AND:  alu = a_reg & opnd2;
            OP_NOT:  alu = ~a_reg;
            default: alu = pcoff;
        endcase
    end

    // main memory read address
    always_comb
    begin
        mem_raddr = '0;
        if (cmd.mem_read)
        begin
            mem_raddr = item_reg.addr[ADDR_BITS-1:0];
        end
        else if (cmd.fetch)
        begin
            mem_raddr = pc_reg[ADDR_BITS-1:0];
        end
        else if (cmd.exec)
        begin
            mem_raddr = (op == OP_LDR) ? baseoff[ADDR_BITS-1:0] : pcoff[ADDR_BITS-1:0];
        end
        else if (cmd.indirect)
        begin
            mem_raddr = mem_rdata[ADDR_BITS-1:0];
        end
    end

    // main memory write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = 16'd0;
        if (cmd.clear)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.mem_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = item_reg.addr[ADDR_BITS-1:0];
            mem_wdata = item_reg.data;
        end
        else if (cmd.exec && (op == OP_ST))
        begin
            mem_we    = 1'b1;
            mem_waddr = pcoff[ADDR_BITS-1:0];
            mem_wdata = rf_val;
        end
        else if (cmd.exec && (op == OP_STR))
        begin
            mem_we    = 1'b1;
            mem_waddr = baseoff[ADDR_BITS-1:0];
            mem_wdata = rf_val;
        end
        else if (cmd.indirect && (op == OP_STI))
        begin
            mem_we    = 1'b1;
            mem_waddr = mem_rdata[ADDR_BITS-1:0];
            mem_wdata = b_reg;
        end
    end

    // register file read address
    always_comb
    begin
        rf_raddr = 3'd0;
        if (cmd.decode)
        begin
            rf_raddr = mem_rdata[8:6];
        end
        else if (cmd.operand)
        begin
            case (op)
                OP_ST, OP_STI, OP_STR: rf_raddr = dr;
                OP_TRAP:               rf_raddr = 3'd0;
                default:               rf_raddr = ins_reg[2:0];
            endcase
        end
    end

    // register file write and flag update
    always_comb
    begin
        rf_we    = 1'b0;
        rf_waddr = dr;
        rf_wdata = alu;
        set_cc   = 1'b0;
        cc_val   = alu;
        if (cmd.exec)
        begin
            case (op)
                OP_ADD, OP_AND, OP_NOT, OP_LEA:
                begin
                    rf_we  = 1'b1;
                    set_cc = 1'b1;
                end
                OP_JSR:
                begin
                    rf_we    = 1'b1;
                    rf_waddr = 3'd7;
                    rf_wdata = pc_reg;
                end
                OP_TRAP:
                begin
                    if ((vec == TV_GETC) || (vec == TV_IN))
                    begin
                        rf_we    = 1'b1;
                        rf_waddr = 3'd0;
                        rf_wdata = {8'd0, item_reg.char_in};
                    end
                end
                default:
                begin
                    rf_we = 1'b0;
                end
            endcase
        end
        else if (cmd.load_data)
        begin
            rf_we    = 1'b1;
            rf_wdata = mem_rdata;
            set_cc   = 1'b1;
            cc_val   = mem_rdata;
        end
    end

    // program counter next value
    always_comb
    begin
        pc_next = pc_reg;
        if (cmd.restart)
        begin
            pc_next = start_pc;
        end
        else if (cmd.decode)
        begin
            pc_next = pc_reg + 16'd1;
        end
        else if (cmd.exec)
        begin
            case (op)
                OP_BR:   pc_next = ((cc_reg & dr) != 3'd0) ? pcoff : pc_reg;
                OP_JMP:  pc_next = a_reg;
                OP_JSR:  pc_next = ins_reg[11] ? (pc_reg + off11) : a_reg;
                default: pc_next = pc_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= START_RESET;
            cc_reg      <= 3'd0;
            halt_reg    <= 1'b0;
            clr_cnt_reg <= '0;
            rf_vld_reg  <= '0;
            cvalid_reg  <= 1'b0;
            took_reg    <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (set_cc)
            begin
                cc_reg <= cc_of(cc_val);
            end
            if (rf_we)
            begin
                rf_vld_reg[rf_waddr] <= 1'b1;
            end
            if (cmd.restart)
            begin
                halt_reg <= 1'b0;
            end
            else if (cmd.exec && (op == OP_TRAP) && (vec == TV_HALT))
            begin
                halt_reg <= 1'b1;
            end
            if (cmd.item_load)
            begin
                cvalid_reg <= 1'b0;
                took_reg   <= 1'b0;
            end
            else if (cmd.exec && (op == OP_TRAP))
            begin
                cvalid_reg <= (vec == TV_OUT);
                took_reg   <= (vec == TV_GETC) || (vec == TV_IN);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rf_rvld_reg <= rf_vld_reg[rf_raddr];
        if (cmd.item_load)
        begin
            item_reg <= item;
            cout_reg <= 8'd0;
        end
        else if (cmd.exec && (op == OP_TRAP) && (vec == TV_OUT))
        begin
            cout_reg <= rf_val[7:0];
        end
        if (cmd.decode)
        begin
            ins_reg <= mem_rdata;
        end
        if (cmd.operand)
        begin
            a_reg <= rf_val;
        end
        if (cmd.exec)
        begin
            b_reg <= rf_val;
        end
        if (cmd.finish)
        begin
            result_reg.read_data  <= (item_reg.func == FN_READ) ? mem_rdata : 16'd0;
            result_reg.pc_now     <= pc_reg;
            result_reg.flags      <= cc_reg;
            result_reg.halted     <= halt_reg;
            result_reg.char_valid <= cvalid_reg;
            result_reg.char_out   <= cout_reg;
            result_reg.took_char  <= took_reg;
        end
    end

    assign result = result_reg;

    // status
    assign sts.opcode     = op;
    assign sts.halted     = halt_reg;
    assign sts.clear_last = &clr_cnt_reg;

    lc3_ram #(
        .WIDTH (16),
        .DEPTH (MEM_WORDS)
    ) u_main_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lc3_ram #(
        .WIDTH (16),
        .DEPTH (8)
    ) u_reg_file (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );
endmodule

@@ hw/rtl/lc3_instruction_core_unit.sv @@
// lc3_instruction_core_unit: top level of the lc-3 instruction core
// depends on lc3_pkg, lc3_ctrl, lc3_dp; holds the apb start_pc register
// write, read, restart pass their own state; a halted step goes straight to finish
// a step: fetch, decode, operand read, execute, up to two dependent memory reads
// throughput: one item at a time, next item accepted after the result beat leaves
// reset: memory is swept to zero one word a cycle, all 65536 words, items stalled
// meanwhile; registers, pc (0x3000), flags and halt mark reset at once
module lc3_instruction_core_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  lc3_pkg::item_t      item,
    output logic                result_valid,
    input  logic                result_stall,
    output lc3_pkg::result_t    result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import lc3_pkg::*;

    logic [15:0] start_pc_reg;
    cmd_t        cmd;
    sts_t        sts;

    assign pready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg <= START_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_START_PC))
        begin
            start_pc_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_START_PC) ? {16'd0, start_pc_reg} : 32'd0;

    lc3_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_func    (item.func),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    lc3_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .item     (item),
        .start_pc (start_pc_reg),
        .result   (result)
    );
endmodule
